FILE: hdl/ecws_pkg.sv
// Shared types and constants for the edge corner weighted select block.
package ecws_pkg;

    typedef struct packed {
        logic               action;
        logic [9:0]         corner_slot;
        logic [9:0]         corner_edge;
        logic signed [31:0] corner_weight;
        logic signed [31:0] query_edge;
        logic signed [31:0] sort_position;
    } t_in_word;

    typedef struct packed {
        logic [9:0]  chosen_corner;
        logic [10:0] total;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_DIV,
        ST_BIT,
        ST_FIND,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        REG_EDGE_COUNT   = 2'd0,
        REG_CORNER_COUNT = 2'd1,
        REG_USE_SORTING  = 2'd2,
        REG_NONE         = 2'd3
    } t_reg;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [31:0] KEY_FLIP = 32'h8000_0000;

endpackage

FILE: hdl/ecws_ram.sv
// Generic single write port, single read port RAM with registered read.
module ecws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: hdl/ecws_mod.sv
// Bit-serial non-negative modulo of a signed 32-bit position by a W-bit divisor (the matching corner count).
module ecws_mod #(
    parameter int W = 11
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic         i_neg,
    input  logic [31:0]  i_mag,
    input  logic [W-1:0] i_div,
    output logic         o_done,
    output logic [W-1:0] o_pos
);

    logic         r_busy;
    logic [4:0]   r_step;
    logic [31:0]  r_dvd;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_div;
    logic         r_neg;
    logic         r_done;
    logic [W:0]   trial;
    logic [W:0]   n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[31]};
        n_rem = (trial >= {1'b0, r_div}) ? trial - {1'b0, r_div} : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 5'd31;
            end else if (r_busy) begin
                r_step <= r_step - 5'd1;
                if (r_step == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_mag;
            r_rem <= '0;
            r_div <= i_div;
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_rem <= n_rem[W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_pos  = (r_neg && r_rem != '0) ? r_div - r_rem : r_rem;

endmodule

FILE: hdl/edge_corner_weighted_select_core.sv
// Top level: corner table memories, query sweep controller and config registers.
// A load word writes the corner tables while the block is idle. A query on an invalid edge
// goes straight to the output register. Otherwise a query sweeps the table: a count pass,
// the modulo, then with sorting 32 radix passes, one final pass and a write into the output
// register; each pass sweeps the live corner count. An empty edge goes from the count pass
// straight to the output register. One word is worked on at a time.
// Reset (synchronous, active low) clears the state, valid flags and config registers; table contents stay.
module edge_corner_weighted_select_core
    import ecws_pkg::*;
#(
    parameter int MAX_CORNERS = 1024,
    parameter int MAX_EDGES   = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_CORNERS);
    localparam int NW = $clog2(MAX_CORNERS + 1);

    t_state r_state, n_state;

    logic [10:0] r_edge_count;
    logic [10:0] r_corner_count;
    logic        r_use_sorting;

    logic [10:0]  r_q, n_q;
    logic [31:0]  r_s, n_s;
    logic [NW-1:0] r_addr, n_addr;
    logic          r_dv;
    logic [CW-1:0] r_didx;
    logic [NW-1:0] r_acc, n_acc;
    logic [NW-1:0] r_total, n_total;
    logic [NW-1:0] r_pos, n_pos;
    logic [4:0]    r_bit, n_bit;
    logic [31:0]   r_pre, n_pre;
    logic [31:0]   r_mask, n_mask;
    logic          r_found, n_found;
    logic [CW-1:0] r_chosen, n_chosen;
    logic          r_out_valid;
    t_out_word     r_out;

    logic          in_acc;
    logic          cfg_wr;
    logic          edge_bad;
    logic [NW-1:0] live_n;
    logic          sweep;
    logic          rd_en;
    logic          sweep_end;
    logic [9:0]    rd_edge;
    logic [31:0]   rd_w;
    logic [31:0]   key;
    logic          hit;
    logic          load_we;
    logic          mod_start;
    logic          mod_done;
    logic [NW-1:0] mod_pos;
    logic          out_go;
    logic [31:0]   live_e;

    assign in_acc = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    assign live_n = (32'(r_corner_count) > MAX_CORNERS) ? NW'(MAX_CORNERS)
                                                        : NW'(r_corner_count);
    assign live_e = (32'(r_edge_count) > MAX_EDGES) ? 32'(MAX_EDGES) : 32'(r_edge_count);
    assign edge_bad = i_in_data.query_edge[31] || (i_in_data.query_edge >= live_e);

    assign sweep = (r_state == ST_COUNT) || (r_state == ST_BIT) || (r_state == ST_FIND);
    assign rd_en = sweep && (r_addr < live_n);
    assign sweep_end = sweep && (r_addr >= live_n) && !r_dv;

    assign load_we = in_acc && (i_in_data.action == ACT_LOAD)
                     && (32'(i_in_data.corner_slot) < MAX_CORNERS);

    ecws_ram #(.WIDTH(10), .DEPTH(MAX_CORNERS)) u_edge_ram (
        .i_clk  (i_clk),
        .i_we   (load_we),
        .i_waddr(CW'(i_in_data.corner_slot)),
        .i_wdata(i_in_data.corner_edge),
        .i_re   (rd_en),
        .i_raddr(r_addr[CW-1:0]),
        .o_rdata(rd_edge)
    );

    ecws_ram #(.WIDTH(32), .DEPTH(MAX_CORNERS)) u_weight_ram (
        .i_clk  (i_clk),
        .i_we   (load_we),
        .i_waddr(CW'(i_in_data.corner_slot)),
        .i_wdata(i_in_data.corner_weight),
        .i_re   (rd_en),
        .i_raddr(r_addr[CW-1:0]),
        .o_rdata(rd_w)
    );

    assign mod_start = (r_state == ST_COUNT) && sweep_end && (r_acc != '0);

    ecws_mod #(.W(NW)) u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mod_start),
        .i_neg  (r_s[31]),
        .i_mag  (r_s[31] ? (~r_s + 32'd1) : r_s),
        .i_div  (r_acc),
        .o_done (mod_done),
        .o_pos  (mod_pos)
    );

    assign key = rd_w ^ KEY_FLIP;
    assign hit = r_dv && ({1'b0, rd_edge} == r_q) && (((key ^ r_pre) & r_mask) == '0);
    assign out_go = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in_data.action == ACT_QUERY) begin
                    n_state = edge_bad ? ST_OUT : ST_COUNT;
                end
            end
            ST_COUNT: begin
                if (sweep_end) begin
                    n_state = (r_acc == '0) ? ST_OUT : ST_DIV;
                end
            end
            ST_DIV: begin
                if (mod_done) begin
                    n_state = r_use_sorting ? ST_BIT : ST_FIND;
                end
            end
            ST_BIT: begin
                if (sweep_end && r_bit == 5'd0) begin
                    n_state = ST_FIND;
                end
            end
            ST_FIND: begin
                if (sweep_end) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_q      = r_q;
        n_s      = r_s;
        n_addr   = r_addr;
        n_acc    = r_acc;
        n_total  = r_total;
        n_pos    = r_pos;
        n_bit    = r_bit;
        n_pre    = r_pre;
        n_mask   = r_mask;
        n_found  = r_found;
        n_chosen = r_chosen;
        if (rd_en) begin
            n_addr = r_addr + NW'(1);
        end
        unique case (r_state)
            ST_IDLE: begin
                n_q      = i_in_data.query_edge[10:0];
                n_s      = i_in_data.sort_position;
                n_addr   = '0;
                n_acc    = '0;
                n_total  = '0;
                n_pre    = '0;
                n_mask   = '0;
                n_bit    = 5'd31;
                n_found  = 1'b0;
                n_chosen = '0;
            end
            ST_COUNT: begin
                if (hit) begin
                    n_acc = r_acc + NW'(1);
                end
                if (sweep_end) begin
                    n_total = r_acc;
                    n_acc   = '0;
                    n_addr  = '0;
                end
            end
            ST_DIV: begin
                if (mod_done) begin
                    n_pos = mod_pos;
                end
            end
            ST_BIT: begin
                if (hit && !key[r_bit]) begin
                    n_acc = r_acc + NW'(1);
                end
                if (sweep_end) begin
                    n_mask[r_bit] = 1'b1;
                    if (r_pos >= r_acc) begin
                        n_pos        = r_pos - r_acc;
                        n_pre[r_bit] = 1'b1;
                    end
                    n_bit  = r_bit - 5'd1;
                    n_acc  = '0;
                    n_addr = '0;
                end
            end
            ST_FIND: begin
                if (hit && !r_found) begin
                    if (r_acc == r_pos) begin
                        n_found  = 1'b1;
                        n_chosen = r_didx;
                    end else begin
                        n_acc = r_acc + NW'(1);
                    end
                end
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_dv           <= 1'b0;
            r_out_valid    <= 1'b0;
            r_edge_count   <= '0;
            r_corner_count <= '0;
            r_use_sorting  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= rd_en;
            if (out_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                unique case (t_reg'(paddr[3:2]))
                    REG_EDGE_COUNT:   r_edge_count   <= pwdata[10:0];
                    REG_CORNER_COUNT: r_corner_count <= pwdata[10:0];
                    REG_USE_SORTING:  r_use_sorting  <= pwdata[0];
                    REG_NONE: begin
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q      <= n_q;
        r_s      <= n_s;
        r_addr   <= n_addr;
        r_acc    <= n_acc;
        r_total  <= n_total;
        r_pos    <= n_pos;
        r_bit    <= n_bit;
        r_pre    <= n_pre;
        r_mask   <= n_mask;
        r_found  <= n_found;
        r_chosen <= n_chosen;
        r_didx   <= r_addr[CW-1:0];
        if (out_go) begin
            r_out.chosen_corner <= 10'(r_chosen);
            r_out.total         <= 11'(r_total);
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[3:2]))
            REG_EDGE_COUNT:   prdata = 32'(r_edge_count);
            REG_CORNER_COUNT: prdata = 32'(r_corner_count);
            REG_USE_SORTING:  prdata = 32'(r_use_sorting);
            REG_NONE:         prdata = '0;
            default:          prdata = '0;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for edge_corner_weighted_select_core: directed and random words.
module tb_top;
    import ecws_pkg::*;

    localparam int DEPTH = 1024;
    localparam int FILL = 64;
    localparam int WATCH_LIMIT = 300000;
    localparam int SETTLE = 20;

    typedef struct packed {
        logic        act;
        logic [9:0]  slot;
        logic [9:0]  edg;
        logic [31:0] wt;
        logic [31:0] qe;
        logic [31:0] sp;
        logic        fixed;
        t_out_word   fx;
    } t_row;

    typedef struct {
        int ec;
        int cc;
        int srt;
        int items;
        bit calm;
    } t_phase;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_word    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    edge_corner_weighted_select_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [9:0]         edge_tab [DEPTH];
    logic signed [31:0] weight_tab [DEPTH];
    int unsigned        edge_lim, corner_lim;
    bit                 by_weight;
    t_out_word          pending_q [$];
    int                 fails = 0;
    bit                 calm = 1'b0;
    int                 quiet_cycles = 0;

    task automatic report(input string what, input t_out_word got, input t_out_word exp);
        $display("mismatch %s: got corner %0d total %0d, exp corner %0d total %0d",
                 what, got.chosen_corner, got.total, exp.chosen_corner, exp.total);
        fails++;
    endtask

    function automatic t_out_word select_corner(input t_in_word w);
        t_out_word    r;
        int unsigned  ne, nc, cnt, rank, seen;
        longint       p;
        r = '0;
        ne = edge_lim > DEPTH ? DEPTH : edge_lim;
        nc = corner_lim > DEPTH ? DEPTH : corner_lim;
        if (w.query_edge < 0 || w.query_edge >= ne) return r;
        cnt = 0;
        for (int k = 0; k < nc; k++) if (edge_tab[k] == w.query_edge) cnt++;
        if (cnt == 0) return r;
        p = longint'(w.sort_position) % longint'(cnt);
        if (p < 0) p += cnt;
        seen = 0;
        for (int k = 0; k < nc; k++) begin
            if (edge_tab[k] != w.query_edge) continue;
            if (by_weight) begin
                rank = 0;
                for (int j = 0; j < nc; j++)
                    if (edge_tab[j] == w.query_edge && (weight_tab[j] < weight_tab[k] ||
                        (weight_tab[j] == weight_tab[k] && j < k))) rank++;
                if (rank == p) begin
                    r.chosen_corner = k[9:0];
                    break;
                end
            end else begin
                if (seen == p) begin
                    r.chosen_corner = k[9:0];
                    break;
                end
                seen++;
            end
        end
        r.total = cnt[10:0];
        return r;
    endfunction

    task automatic send(input t_in_word w, input bit fixed, input t_out_word fx);
        while (!calm && $urandom_range(0, 99) < 37) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        if (w.action == ACT_LOAD) begin
            edge_tab[w.corner_slot] = w.corner_edge;
            weight_tab[w.corner_slot] = w.corner_weight;
        end else begin
            pending_q.push_back(fixed ? fx : select_corner(w));
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(input t_reg idx, input int unsigned val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_EDGE_COUNT: begin
                edge_lim = val & 11'h7FF;
            end
            REG_CORNER_COUNT: begin
                corner_lim = val & 11'h7FF;
            end
            REG_USE_SORTING: begin
                by_weight = val[0];
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= !calm && $urandom_range(0, 99) < 37;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                report("unexpected word", o_out_data, '0);
            end else begin
                if (o_out_data !== pending_q[0]) report("result", o_out_data, pending_q[0]);
                void'(pending_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCH_LIMIT) begin
            $display("timeout");
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_row         plan [18];
        t_phase       phases [7];
        t_in_word     w;
        logic [127:0] raw;
        edge_lim = 0;
        corner_lim = 0;
        by_weight = 1'b0;
        plan = '{
            '{ACT_LOAD,  10'd0,    10'd5,    32'h7FFF_FFFF, 32'd0, 32'd0, 1'b0, '0},
            '{ACT_LOAD,  10'd3,    10'd5,    32'h8000_0000, 32'd0, 32'd0, 1'b0, '0},
            '{ACT_LOAD,  10'd7,    10'd5,    32'd0,         32'd0, 32'd0, 1'b0, '0},
            '{ACT_LOAD,  10'd12,   10'd5,    32'd0,         32'd0, 32'd0, 1'b0, '0},
            '{ACT_LOAD,  10'd1023, 10'd1023, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0, '0},
            '{ACT_QUERY, 10'd0, 10'd0, 32'd0, 32'd5,          32'd0,         1'b0, '0},
            '{ACT_QUERY, 10'd0, 10'd0, 32'd0, 32'd5,          32'hFFFF_FFFF, 1'b0, '0},
            '{ACT_QUERY, 10'd0, 10'd0, 32'd0, 32'd5,          32'h8000_0000, 1'b0, '0},
            '{ACT_QUERY, 10'd0, 10'd0, 32'd0, 32'd5,          32'h7FFF_FFFF, 1'b0, '0},
            '{ACT_QUERY, 10'd0, 10'd0, 32'd0, 32'd5,          32'd2,         1'b0, '0},
            '{ACT_QUERY, 10'd0, 10'd0, 32'd0, 32'hFFFF_FFFF,  32'd0,         1'b1, '0},
            '{ACT_QUERY, 10'd0, 10'd0, 32'd0, 32'h8000_0000,  32'd1,         1'b1, '0},
            '{ACT_QUERY, 10'd0, 10'd0, 32'd0, 32'h7FFF_FFFF,  32'd1,         1'b1, '0},
            '{ACT_QUERY, 10'd0, 10'd0, 32'd0, 32'd1024,       32'd0,         1'b1, '0},
            '{ACT_QUERY, 10'd0, 10'd0, 32'd0, 32'd1023,       32'd0,         1'b1, '0},
            '{ACT_QUERY, 10'd0, 10'd0, 32'd0, 32'd0,          32'd5,         1'b0, '0},
            '{ACT_LOAD,  10'd5, 10'd5, 32'h8000_0000, 32'd0,  32'd0,         1'b0, '0},
            '{ACT_QUERY, 10'd0, 10'd0, 32'd0, 32'd5,          32'd1,         1'b0, '0}
        };
        phases = '{
            '{8, 16, 0, 40, 1'b0},
            '{8, 16, 1, 40, 1'b0},
            '{4, 4, 1, 40, 1'b1},
            '{2047, 64, 0, 40, 1'b0},
            '{0, 32, 1, 20, 1'b0},
            '{1024, 64, 0, 12, 1'b0},
            '{16, 64, 1, 8, 1'b0}
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every entry that the corner counts below can reach
        calm = 1'b1;
        for (int k = 0; k < FILL; k++) begin
            raw = {$urandom, $urandom, $urandom, $urandom};
            w = raw[$bits(t_in_word)-1:0];
            w.action = ACT_LOAD;
            w.corner_slot = k[9:0];
            w.corner_edge = 10'($urandom_range(0, 3));
            w.corner_weight = ($urandom_range(0, 3) == 0) ? $urandom
                                                          : $urandom_range(0, 6) - 3;
            send(w, 1'b0, '0);
        end
        calm = 1'b0;
        settle();

        for (int pass = 0; pass < 2; pass++) begin
            reg_write(REG_EDGE_COUNT, 1024);
            reg_write(REG_CORNER_COUNT, 16);
            reg_write(REG_USE_SORTING, pass);
            foreach (plan[i]) begin
                w = '0;
                w.action = plan[i].act;
                w.corner_slot = plan[i].slot;
                w.corner_edge = plan[i].edg;
                w.corner_weight = plan[i].wt;
                w.query_edge = plan[i].qe;
                w.sort_position = plan[i].sp;
                send(w, plan[i].fixed, plan[i].fx);
            end
            settle();
        end

        foreach (phases[p]) begin
            reg_write(REG_EDGE_COUNT, phases[p].ec);
            reg_write(REG_CORNER_COUNT, phases[p].cc);
            reg_write(REG_USE_SORTING, phases[p].srt);
            calm = phases[p].calm;
            for (int i = 0; i < phases[p].items; i++) begin
                raw = {$urandom, $urandom, $urandom, $urandom};
                w = raw[$bits(t_in_word)-1:0];
                w.action = ($urandom_range(0, 99) < 35) ? ACT_LOAD : ACT_QUERY;
                if ($urandom_range(0, 9) < 7)
                    w.corner_slot = 10'($urandom_range(0, phases[p].cc > 1024 ? 1023
                                                          : phases[p].cc - 1));
                if ($urandom_range(0, 3) != 0) w.corner_edge = 10'($urandom_range(0, 3));
                if ($urandom_range(0, 1) != 0) w.corner_weight = $urandom_range(0, 6) - 3;
                if ($urandom_range(0, 4) != 0) w.query_edge = $urandom_range(0, 5);
                if ($urandom_range(0, 1) != 0) w.sort_position = $urandom_range(0, 9);
                send(w, 1'b0, '0);
            end
            calm = 1'b0;
            settle();
        end

        if (fails == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: files.f
hdl/ecws_pkg.sv
hdl/ecws_ram.sv
hdl/ecws_mod.sv
hdl/edge_corner_weighted_select_core.sv
tb/sv/tb_top.sv
